// ----- hdl/bpc_pkg.sv -----
`default_nettype none

package bpc_pkg;

  // One input item: a raw pressure and a raw temperature reading
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } bpc_in_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [24:0]        pressure_centi;
  } bpc_out_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CALIB_LOW     = 3'd0,
    REG_CALIB_MID     = 3'd1,
    REG_CALIB_HIGH    = 3'd2,
    REG_TEMP_FLOOR    = 3'd3,
    REG_TEMP_CEILING  = 3'd4,
    REG_PRESS_FLOOR   = 3'd5,
    REG_PRESS_CEILING = 3'd6
  } bpc_reg_t;

  // Unpacked calibration coefficients (integer parts only; scales are fixed)
  typedef struct packed {
    logic [15:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } bpc_coef_t;

  // Result limits
  typedef struct packed {
    logic signed [15:0] temp_floor;
    logic signed [15:0] temp_ceiling;
    logic [24:0]        press_floor;
    logic [24:0]        press_ceiling;
  } bpc_lim_t;

  // Temperature stage to pressure stage
  typedef struct packed {
    logic signed [27:0] ta;
    logic signed [15:0] tcenti;
    logic [23:0]        rp;
  } bpc_temp_t;

  localparam int TEMP_STAGES  = 9;
  localparam int PRESS_STAGES = 10;
  localparam int TOTAL_LAT    = TEMP_STAGES + PRESS_STAGES;

  localparam logic signed [15:0] TEMP_FLOOR_RST    = -16'sd4000;
  localparam logic signed [15:0] TEMP_CEILING_RST  = 16'sd8500;
  localparam logic [24:0]        PRESS_FLOOR_RST   = 25'd3000000;
  localparam logic [24:0]        PRESS_CEILING_RST = 25'd12500000;

  localparam logic signed [16:0] P_OFFSET = 17'sd16384;

  // Rounding half of 2^46, and of 25 * 2^30; offset 25 * 2^27 for the divide
  localparam logic signed [63:0] TC_HALF = 64'sd35184372088832;
  localparam logic signed [63:0] Y_HALF  = 64'sd13421772800;
  localparam logic signed [63:0] Y_OFS   = 64'sd3355443200;
  // floor(2^33 / 25)
  localparam logic [28:0]        RECIP25 = 29'd343597383;
  localparam int                 RECIP_SHIFT = 33;
  localparam logic [33:0]        DIV25   = 34'd25;
  localparam logic [29:0]        TA_OFS  = 30'd134217728;

endpackage

`default_nettype wire

// ----- hdl/bpc_cfg_regs.sv -----
`default_nettype none

module bpc_cfg_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  output bpc_pkg::bpc_coef_t       coef,
  output bpc_pkg::bpc_lim_t        lim
);
  import bpc_pkg::*;

  logic [63:0]  calib_low;
  logic [63:0]  calib_mid;
  logic [39:0]  calib_high;
  logic [167:0] calib;
  bpc_lim_t     lim_reg;

  // Always take writes
  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_low              <= '0;
      calib_mid              <= '0;
      calib_high             <= '0;
      lim_reg.temp_floor     <= TEMP_FLOOR_RST;
      lim_reg.temp_ceiling   <= TEMP_CEILING_RST;
      lim_reg.press_floor    <= PRESS_FLOOR_RST;
      lim_reg.press_ceiling  <= PRESS_CEILING_RST;
    end else if (cfg_valid) begin
      case (bpc_reg_t'(cfg_index))
        REG_CALIB_LOW:     calib_low             <= cfg_data;
        REG_CALIB_MID:     calib_mid             <= cfg_data;
        REG_CALIB_HIGH:    calib_high            <= cfg_data[39:0];
        REG_TEMP_FLOOR:    lim_reg.temp_floor    <= cfg_data[15:0];
        REG_TEMP_CEILING:  lim_reg.temp_ceiling  <= cfg_data[15:0];
        REG_PRESS_FLOOR:   lim_reg.press_floor   <= cfg_data[24:0];
        REG_PRESS_CEILING: lim_reg.press_ceiling <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // Unpack the 21 calibration bytes
  assign calib = {calib_high, calib_mid, calib_low};

  always_comb begin
    coef.t1  = calib[15:0];
    coef.t2  = calib[31:16];
    coef.t3  = calib[39:32];
    coef.p1  = 17'($signed(calib[55:40])) - P_OFFSET;
    coef.p2  = 17'($signed(calib[71:56])) - P_OFFSET;
    coef.p3  = calib[79:72];
    coef.p4  = calib[87:80];
    coef.p5  = calib[103:88];
    coef.p6  = calib[119:104];
    coef.p7  = calib[127:120];
    coef.p8  = calib[135:128];
    coef.p9  = calib[151:136];
    coef.p10 = calib[159:152];
    coef.p11 = calib[167:160];
  end

  assign lim = lim_reg;

endmodule

`default_nettype wire

// ----- hdl/bpc_temp_pipe.sv -----
`default_nettype none

module bpc_temp_pipe (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire bpc_pkg::bpc_in_t    in_item,
  input  wire bpc_pkg::bpc_coef_t  coef,
  input  wire bpc_pkg::bpc_lim_t   lim,
  output logic                     out_valid,
  output bpc_pkg::bpc_temp_t       out_item
);
  import bpc_pkg::*;

  logic [TEMP_STAGES-1:0] vld;
  logic [23:0]            rp_pipe [TEMP_STAGES];

  logic signed [24:0] d_s1;
  logic signed [41:0] a_s2;
  logic signed [49:0] dd_s2;
  logic signed [41:0] a_s3;
  logic signed [57:0] m_s3;
  logic signed [63:0] x_s4;
  logic signed [63:0] xc_s5;
  logic signed [15:0] tc_s6, tc_s7, tc_s8, tc_s9;
  logic [33:0]        yy_s6, yy_s7, yy_s8;
  logic [62:0]        prod_s7;
  logic [29:0]        qe_s8;
  logic signed [27:0] ta_s9;

  logic signed [63:0] sum_s3;
  logic signed [63:0] tf64, tc64, x_lo, xc_next;
  logic signed [63:0] yw;
  logic [33:0]        rem;
  logic [29:0]        q;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TEMP_STAGES-2:0], in_valid};
    end
  end

  // Combinational pieces between stages
  always_comb begin
    sum_s3  = (64'(a_s3) <<< 18) + 64'(m_s3);
    tf64    = 64'(lim.temp_floor) <<< 46;
    tc64    = 64'(lim.temp_ceiling) <<< 46;
    // floor first, ceiling second
    x_lo    = (x_s4 < tf64) ? tf64 : x_s4;
    xc_next = (x_lo > tc64) ? tc64 : x_lo;
    yw      = ((xc_s5 + Y_HALF) >>> 30) + Y_OFS;
    rem     = yy_s8 - (34'(qe_s8) * DIV25);
    q       = qe_s8 + 30'(rem >= DIV25);
  end

  // Payload stages
  always_ff @(posedge clk) begin
    rp_pipe[0] <= in_item.raw_pressure;
    for (int i = 1; i < TEMP_STAGES; i++) begin
      rp_pipe[i] <= rp_pipe[i-1];
    end
    // offset from the reference point
    d_s1  <= $signed({1'b0, in_item.raw_temperature}) - $signed({1'b0, coef.t1, 8'h00});
    // linear and square terms
    a_s2  <= 42'(d_s1) * 42'($signed({1'b0, coef.t2}));
    dd_s2 <= 50'(d_s1) * 50'(d_s1);
    a_s3  <= a_s2;
    m_s3  <= 58'(dd_s2) * 58'(coef.t3);
    // scaled temperature, 25 * 2^48
    x_s4  <= sum_s3 * 64'sd25;
    xc_s5 <= xc_next;
    // centidegrees and the offset dividend for the 18-bit temperature
    tc_s6 <= 16'((xc_s5 + TC_HALF) >>> 46);
    yy_s6 <= 34'(yw);
    // divide by 25: reciprocal, then one correction
    prod_s7 <= 63'(yy_s6) * 63'(RECIP25);
    yy_s7   <= yy_s6;
    tc_s7   <= tc_s6;
    qe_s8   <= prod_s7[62:RECIP_SHIFT];
    yy_s8   <= yy_s7;
    tc_s8   <= tc_s7;
    ta_s9   <= 28'(q - TA_OFS);
    tc_s9   <= tc_s8;
  end

  assign out_valid       = vld[TEMP_STAGES-1];
  assign out_item.ta     = ta_s9;
  assign out_item.tcenti = tc_s9;
  assign out_item.rp     = rp_pipe[TEMP_STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/bpc_press_pipe.sv -----
`default_nettype none

module bpc_press_pipe (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire bpc_pkg::bpc_temp_t  in_item,
  input  wire bpc_pkg::bpc_coef_t  coef,
  input  wire bpc_pkg::bpc_lim_t   lim,
  output logic                     out_valid,
  output bpc_pkg::bpc_out_t        out_item
);
  import bpc_pkg::*;

  logic [PRESS_STAGES-1:0] vld;

  logic signed [24:0] rp_in;
  logic signed [16:0] p5s, p6s;

  logic signed [27:0] ta_q1, ta_q2;
  logic signed [24:0] rp_q1, rp_q2, rp_q3, rp_q4, rp_q5, rp_q6;
  logic signed [15:0] tc_q1, tc_q2, tc_q3, tc_q4, tc_q5, tc_q6, tc_q7, tc_q8, tc_q9;
  logic signed [55:0] ta2_q1;
  logic signed [44:0] p2ta_q1;
  logic signed [44:0] p6ta_q1, p6ta_q2, p6ta_q3, p6ta_q4, p6ta_q5;
  logic signed [35:0] p10ta_q1;
  logic signed [48:0] rp2_q1;
  logic signed [35:0] tb_q2;
  logic signed [36:0] quad_q2;
  logic signed [37:0] sp2_q2, sp2_q3, sp2_q4, sp2_q5;
  logic signed [56:0] rp2p11_q2;
  logic signed [63:0] tbta_q3;
  logic signed [43:0] p3tb_q3, p3tb_q4, p3tb_q5;
  logic signed [43:0] p7tb_q3, p7tb_q4, p7tb_q5;
  logic signed [61:0] wprod_q3;
  logic signed [39:0] w2_q3;
  logic signed [45:0] tcu_q4;
  logic signed [41:0] w_q4;
  logic signed [63:0] rpw2_q4, rpw2_q5, rpw2_q6, rpw2_q7;
  logic signed [53:0] p8tcu_q5, p4tcu_q5;
  logic signed [65:0] rpw_q5, rpw_q6, rpw_q7;
  logic signed [57:0] base_q6, base_q7;
  logic signed [41:0] slope_q6;
  logic signed [66:0] rps_q7;
  logic signed [59:0] acc_q8;
  logic signed [64:0] acc25_q9;
  bpc_out_t           res_q10;

  logic signed [34:0] pcr, pf35, pc35, p_lo, p_hi;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PRESS_STAGES-2:0], in_valid};
    end
  end

  // Unsigned operands as signed values
  assign rp_in = $signed({1'b0, in_item.rp});
  assign p5s   = $signed({1'b0, coef.p5});
  assign p6s   = $signed({1'b0, coef.p6});

  // Final round and clamp, floor first
  always_comb begin
    pcr  = 35'((acc25_q9 + 65'sd536870912) >>> 30);
    pf35 = $signed({10'b0, lim.press_floor});
    pc35 = $signed({10'b0, lim.press_ceiling});
    p_lo = (pcr < pf35) ? pf35 : pcr;
    p_hi = (p_lo > pc35) ? pc35 : p_lo;
  end

  always_ff @(posedge clk) begin
    // Products with the temperature
    ta_q1    <= in_item.ta;
    rp_q1    <= rp_in;
    tc_q1    <= in_item.tcenti;
    ta2_q1   <= 56'(in_item.ta) * 56'(in_item.ta);
    p2ta_q1  <= 45'(in_item.ta) * 45'(coef.p2);
    p6ta_q1  <= 45'(in_item.ta) * 45'(p6s);
    p10ta_q1 <= 36'(in_item.ta) * 36'(coef.p10);
    rp2_q1   <= 49'(rp_in) * 49'(rp_in);

    // Square of temperature, quadratic bracket
    ta_q2     <= ta_q1;
    rp_q2     <= rp_q1;
    tc_q2     <= tc_q1;
    p6ta_q2   <= p6ta_q1;
    tb_q2     <= 36'((ta2_q1 + 56'sd131072) >>> 18);
    quad_q2   <= (37'(coef.p9) <<< 18) + 37'(p10ta_q1);
    sp2_q2    <= 38'((p2ta_q1 + 45'sd64) >>> 7);
    rp2p11_q2 <= 57'(rp2_q1) * 57'(coef.p11);

    // Cube product, square terms, quadratic products
    rp_q3    <= rp_q2;
    tc_q3    <= tc_q2;
    p6ta_q3  <= p6ta_q2;
    sp2_q3   <= sp2_q2;
    tbta_q3  <= 64'(tb_q2) * 64'(ta_q2);
    p3tb_q3  <= 44'(tb_q2) * 44'(coef.p3);
    p7tb_q3  <= 44'(tb_q2) * 44'(coef.p7);
    wprod_q3 <= 62'(rp_q2) * 62'(quad_q2);
    w2_q3    <= 40'((rp2p11_q2 + 57'sd65536) >>> 17);

    // Round the cube and the quadratic bracket
    rp_q4   <= rp_q3;
    tc_q4   <= tc_q3;
    p6ta_q4 <= p6ta_q3;
    sp2_q4  <= sp2_q3;
    p3tb_q4 <= p3tb_q3;
    p7tb_q4 <= p7tb_q3;
    tcu_q4  <= 46'((tbta_q3 + 64'sd131072) >>> 18);
    w_q4    <= 42'((wprod_q3 + 62'sd524288) >>> 20);
    rpw2_q4 <= 64'(rp_q3) * 64'(w2_q3);

    // Cube terms
    rp_q5    <= rp_q4;
    tc_q5    <= tc_q4;
    p6ta_q5  <= p6ta_q4;
    sp2_q5   <= sp2_q4;
    p3tb_q5  <= p3tb_q4;
    p7tb_q5  <= p7tb_q4;
    rpw2_q5  <= rpw2_q4;
    p8tcu_q5 <= 54'(tcu_q4) * 54'(coef.p8);
    p4tcu_q5 <= 54'(tcu_q4) * 54'(coef.p4);
    rpw_q5   <= 66'(rp_q4) * 66'(w_q4);

    // Offset group at 32 fraction bits, linear bracket at 40
    rp_q6    <= rp_q5;
    tc_q6    <= tc_q5;
    rpw_q6   <= rpw_q5;
    rpw2_q6  <= rpw2_q5;
    base_q6  <= (58'(p5s) <<< 35) + (58'(p6ta_q5) <<< 8) + (58'(p7tb_q5) <<< 6)
              + 58'((p8tcu_q5 + 54'sd1) >>> 1);
    slope_q6 <= (42'(coef.p1) <<< 20) + 42'(sp2_q5)
              + 42'((p3tb_q5 + 44'sd512) >>> 10)
              + 42'((p4tcu_q5 + 54'sd16384) >>> 15);

    // Linear bracket times the reading
    tc_q7   <= tc_q6;
    base_q7 <= base_q6;
    rpw_q7  <= rpw_q6;
    rpw2_q7 <= rpw2_q6;
    rps_q7  <= 67'(rp_q6) * 67'(slope_q6);

    // Sum at 32 fraction bits
    tc_q8  <= tc_q7;
    acc_q8 <= 60'(base_q7) + 60'((rps_q7 + 67'sd128) >>> 8)
            + 60'((rpw_q7 + 66'sd8192) >>> 14) + 60'((rpw2_q7 + 64'sd32768) >>> 16);

    // Scale to centipascal
    tc_q9    <= tc_q8;
    acc25_q9 <= 65'(acc_q8) * 65'sd25;

    res_q10.temperature_centi <= tc_q9;
    res_q10.pressure_centi    <= p_hi[24:0];
  end

  assign out_valid = vld[PRESS_STAGES-1];
  assign out_item  = res_q10;

endmodule

`default_nettype wire

// ----- hdl/baro_temp_pressure_compensation_unit.sv -----
`default_nettype none

// Barometric compensation: one raw pressure/temperature pair in, one compensated
// pair out. An item is taken on any cycle with start high and busy low; busy is
// high only during reset, so the unit takes one item every cycle. Each result
// appears on result with done high for exactly one cycle, once its item has
// passed 9 stages of temperature math and a 25-way divide, then 10 stages of
// the pressure polynomial; there is no way to hold results off, so the receiver
// must take every done pulse. Configuration writes are always ready and apply
// from the next cycle; write them only with no items in flight.

module baro_temp_pressure_compensation_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire bpc_pkg::bpc_in_t   req,
  output logic                    done,
  output bpc_pkg::bpc_out_t       result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import bpc_pkg::*;

  bpc_coef_t coef;
  bpc_lim_t  lim;
  logic      accept;
  logic      t_valid;
  bpc_temp_t t_item;

  assign busy   = rst;
  assign accept = start && !busy;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef),
    .lim       (lim)
  );

  bpc_temp_pipe u_temp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_item   (req),
    .coef      (coef),
    .lim       (lim),
    .out_valid (t_valid),
    .out_item  (t_item)
  );

  bpc_press_pipe u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .in_item   (t_item),
    .coef      (coef),
    .lim       (lim),
    .out_valid (done),
    .out_item  (result)
  );

endmodule

`default_nettype wire

// ----- hdl/bpc_checker.sv -----
`default_nettype none

module bpc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);
  import bpc_pkg::*;

  // Every accepted item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("accepted item did not produce a result");

  // No result without an item taken at the matching cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching item");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

endmodule

bind baro_temp_pressure_compensation_unit bpc_checker u_chk (.*);

`default_nettype wire

// ----- sim/baro_temp_pressure_compensation_unit_tb.sv -----
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_unit_tb;
  import bpc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 190;

  // Sample calibration with coefficients in their usual ranges
  localparam logic [63:0] CAL_LOW  = 64'hA0FFC0F94A386978;
  localparam logic [63:0] CAL_MID  = 64'h032D0030D4FE0508;
  localparam logic [39:0] CAL_HIGH = 40'hE8081234F2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bpc_in_t req = '0;
  logic done;
  bpc_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  baro_temp_pressure_compensation_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers
  logic [63:0] cal_low, cal_mid;
  logic [39:0] cal_high;
  logic signed [15:0] t_floor, t_ceil;
  logic [24:0] p_floor, p_ceil;

  bpc_out_t comp_expected_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit pin_result = 1'b0;
  bpc_out_t pinned_result;

  function automatic longint div_down(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint round_div(longint a, longint d);
    return div_down(a + d / 2, d);
  endfunction

  function automatic logic [7:0] cal_byte(int k);
    if (k < 8) return cal_low[8*k +: 8];
    if (k < 16) return cal_mid[8*(k-8) +: 8];
    return cal_high[8*(k-16) +: 8];
  endfunction

  function automatic longint cal_u16(int k);
    logic [15:0] v;
    v = {cal_byte(k + 1), cal_byte(k)};
    return longint'(v);
  endfunction

  function automatic longint cal_s16(int k);
    logic signed [15:0] v;
    v = {cal_byte(k + 1), cal_byte(k)};
    return longint'(v);
  endfunction

  function automatic longint cal_s8(int k);
    logic signed [7:0] v;
    v = cal_byte(k);
    return longint'(v);
  endfunction

  // Compute compensated temperature and pressure from the shadow config
  function automatic bpc_out_t compensate(bpc_in_t it);
    longint rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint tf, tc, pf, pcl, d, x, tcenti, ta, tb, tcu;
    longint base, slope, quad, w, w2, acc, pc;
    bpc_out_t o;
    rp = longint'(it.raw_pressure);
    rt = longint'(it.raw_temperature);
    t1 = cal_u16(0); t2 = cal_u16(2); t3 = cal_s8(4);
    p1 = cal_s16(5) - 16384; p2 = cal_s16(7) - 16384;
    p3 = cal_s8(9); p4 = cal_s8(10); p5 = cal_u16(11); p6 = cal_u16(13);
    p7 = cal_s8(15); p8 = cal_s8(16); p9 = cal_s16(17); p10 = cal_s8(19);
    p11 = cal_s8(20);
    tf = longint'(t_floor); tc = longint'(t_ceil);
    pf = longint'(p_floor); pcl = longint'(p_ceil);
    // linearized temperature at 25 * 2^48, floor then ceiling
    d = rt - t1 * 256;
    x = (d * t2 * (64'sd1 << 18) + d * d * t3) * 25;
    if (x < tf * (64'sd1 << 46)) x = tf * (64'sd1 << 46);
    if (x > tc * (64'sd1 << 46)) x = tc * (64'sd1 << 46);
    tcenti = round_div(x, 64'sd1 << 46);
    // temperature powers at 18 fraction bits
    ta = round_div(x, 25 * (64'sd1 << 30));
    tb = round_div(ta * ta, 64'sd1 << 18);
    tcu = round_div(tb * ta, 64'sd1 << 18);
    // polynomial summed at 32 fraction bits
    base = p5 * (64'sd1 << 35) + p6 * ta * 256 + p7 * tb * 64 + round_div(p8 * tcu, 2);
    slope = p1 * (64'sd1 << 20) + round_div(p2 * ta, 128) + round_div(p3 * tb, 1024)
          + round_div(p4 * tcu, 32768);
    quad = p9 * (64'sd1 << 18) + p10 * ta;
    w = round_div(rp * quad, 64'sd1 << 20);
    w2 = round_div(rp * rp * p11, 131072);
    acc = base + round_div(rp * slope, 256) + round_div(rp * w, 16384)
        + round_div(rp * w2, 65536);
    pc = round_div(acc * 25, 64'sd1 << 30);
    if (pc < pf) pc = pf;
    if (pc > pcl) pc = pcl;
    o.temperature_centi = tcenti[15:0];
    o.pressure_centi = pc[24:0];
    return o;
  endfunction

  // Track config writes, queue expectations, check results
  always @(posedge clk) begin
    bpc_out_t e;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CALIB_LOW:     cal_low <= cfg_data;
          REG_CALIB_MID:     cal_mid <= cfg_data;
          REG_CALIB_HIGH:    cal_high <= cfg_data[39:0];
          REG_TEMP_FLOOR:    t_floor <= cfg_data[15:0];
          REG_TEMP_CEILING:  t_ceil <= cfg_data[15:0];
          REG_PRESS_FLOOR:   p_floor <= cfg_data[24:0];
          REG_PRESS_CEILING: p_ceil <= cfg_data[24:0];
          default: ;
        endcase
      end
      if (done) begin
        results_seen++;
        if (comp_expected_q.size() == 0) begin
          $error("result with nothing expected: temp %0d press %0d",
                 result.temperature_centi, result.pressure_centi);
          errors++;
        end else begin
          e = comp_expected_q.pop_front();
          if (result.temperature_centi !== e.temperature_centi) begin
            $error("temperature_centi expected %0d actual %0d",
                   e.temperature_centi, result.temperature_centi);
            errors++;
          end
          if (result.pressure_centi !== e.pressure_centi) begin
            $error("pressure_centi expected %0d actual %0d",
                   e.pressure_centi, result.pressure_centi);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        items_sent++;
        comp_expected_q.push_back(pin_result ? pinned_result : compensate(req));
      end
    end
  end

  // Hold one item on the command port until taken; caller is at a falling edge
  task automatic send_item(bpc_in_t it, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (comp_expected_q.size() != 0) @(negedge clk);
    repeat (TOTAL_LAT + 4) @(negedge clk);
  endtask

  // One write, with valid dropped again before the task returns
  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_limits(logic [63:0] tf, logic [63:0] tc,
                              logic [63:0] pf, logic [63:0] pc);
    write_reg(REG_TEMP_FLOOR, tf);
    write_reg(REG_TEMP_CEILING, tc);
    write_reg(REG_PRESS_FLOOR, pf);
    write_reg(REG_PRESS_CEILING, pc);
  endtask

  task automatic write_calib(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
    write_reg(REG_CALIB_LOW, lo);
    write_reg(REG_CALIB_MID, mid);
    write_reg(REG_CALIB_HIGH, hi);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Directed rows: group selects the config applied before the row
  typedef struct {
    int       group;
    bpc_in_t  stim;
    bit       pinned;
    bpc_out_t want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // reset config: zero calibration gives 0 C and the pressure floor
    '{0, '{24'd0, 24'd0}, 1'b1, '{16'sd0, 25'd3000000}},
    '{0, '{24'hFFFFFF, 24'hFFFFFF}, 1'b1, '{16'sd0, 25'd3000000}},
    '{0, '{24'hFFFFFF, 24'd0}, 1'b1, '{16'sd0, 25'd3000000}},
    '{0, '{24'd0, 24'hFFFFFF}, 1'b1, '{16'sd0, 25'd3000000}},
    // floors above ceilings: the ceilings win
    '{1, '{24'd0, 24'd0}, 1'b1, '{-16'sd1000, 25'd1000000}},
    '{1, '{24'hFFFFFF, 24'hFFFFFF}, 1'b1, '{-16'sd1000, 25'd1000000}},
    '{1, '{24'h800000, 24'h7FFFFF}, 1'b1, '{-16'sd1000, 25'd1000000}},
    // sample calibration, widest limits
    '{2, '{24'd0, 24'd0}, 1'b0, '{16'sd0, 25'd0}},
    '{2, '{24'hFFFFFF, 24'hFFFFFF}, 1'b0, '{16'sd0, 25'd0}},
    '{2, '{24'h600000, 24'h697800}, 1'b0, '{16'sd0, 25'd0}},
    '{2, '{24'h7A1200, 24'h69F000}, 1'b0, '{16'sd0, 25'd0}},
    '{2, '{24'h500000, 24'h690000}, 1'b0, '{16'sd0, 25'd0}},
    '{2, '{24'hA00000, 24'h6B0000}, 1'b0, '{16'sd0, 25'd0}},
    // all-ones calibration, limit registers at their bit extremes
    '{3, '{24'd0, 24'd0}, 1'b0, '{16'sd0, 25'd0}},
    '{3, '{24'hFFFFFF, 24'hFFFFFF}, 1'b0, '{16'sd0, 25'd0}},
    '{3, '{24'h123456, 24'hFEDCBA}, 1'b0, '{16'sd0, 25'd0}}
  };

  task automatic apply_group(int g);
    drain();
    case (g)
      1: write_limits(64'sd3000, -64'sd1000, 64'd5000000, 64'd1000000);
      2: begin
        write_calib(CAL_LOW, CAL_MID, {24'd0, CAL_HIGH});
        write_limits(16'h8000, 16'h7FFF, 64'd0, 64'h1FFFFFF);
      end
      3: begin
        write_calib('1, '1, '1);
        write_limits('1, 64'h7FFF, 64'd0, '1);
      end
      default: ;
    endcase
  endtask

  // Pick a calibration and limits for one random phase
  task automatic setup_phase(int ph);
    logic [63:0] lo, mid, hi;
    drain();
    case (ph % 4)
      0: begin lo = CAL_LOW; mid = CAL_MID; hi = CAL_HIGH; end
      1: begin lo = rand64(); mid = rand64(); hi = rand64(); end
      2: begin
        lo = CAL_LOW ^ (rand64() & 64'hFF00FF00FF00FF00);
        mid = CAL_MID ^ (rand64() & 64'h00FF00FF00FF00FF);
        hi = CAL_HIGH ^ (rand64() & 64'hFF00FF00FF);
      end
      default: begin lo = '0; mid = rand64(); hi = '1; end
    endcase
    write_calib(lo, mid, hi);
    case (ph % 3)
      0: write_limits(16'h8000, 16'h7FFF, 64'd0, 64'h1FFFFFF);
      1: write_limits(-64'sd4000, 64'd8500, 64'd3000000, 64'd12500000);
      default: write_limits(rand64(), rand64(), rand64(), rand64());
    endcase
    if (ph == 1) write_reg(REG_UNUSED, rand64());
  endtask

  initial begin
    bpc_in_t it;
    int cur_group, idle_pct;
    logic [23:0] t_base;
    cal_low = '0; cal_mid = '0; cal_high = '0;
    t_floor = TEMP_FLOOR_RST; t_ceil = TEMP_CEILING_RST;
    p_floor = PRESS_FLOOR_RST; p_ceil = PRESS_CEILING_RST;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    cur_group = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].group != cur_group) begin
        cur_group = dir_rows[i].group;
        apply_group(cur_group);
      end
      pin_result = dir_rows[i].pinned;
      pinned_result = dir_rows[i].want;
      send_item(dir_rows[i].stim, 0);
    end
    pin_result = 1'b0;

    // Random phases, sender idling light, heavier, then not at all
    for (int ph = 0; ph < PHASES; ph++) begin
      setup_phase(ph);
      idle_pct = (ph < 2) ? 38 : (ph < 4) ? 53 : 0;
      t_base = {cal_low[15:0], 8'd0};
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.raw_pressure = 24'($urandom);
        if ($urandom_range(99) < 70)
          it.raw_temperature = t_base + 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
        else
          it.raw_temperature = 24'($urandom);
        // let the pipeline run dry once mid-phase
        if (ph == 2 && n == 60) begin
          start <= 1'b0;
          while (comp_expected_q.size() != 0) @(negedge clk);
        end
        send_item(it, idle_pct);
      end
    end

    start <= 1'b0;
    while (comp_expected_q.size() != 0) @(negedge clk);
    repeat (TOTAL_LAT + 10) @(negedge clk);
    $display("Covered %0d items, %0d results, over %0d configurations.",
             items_sent, results_seen, PHASES + 4);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bpc_pkg.sv
hdl/bpc_cfg_regs.sv
hdl/bpc_temp_pipe.sv
hdl/bpc_press_pipe.sv
hdl/baro_temp_pressure_compensation_unit.sv
hdl/bpc_checker.sv
sim/baro_temp_pressure_compensation_unit_tb.sv
